### rtl/core/tpsd_pkg.sv
`timescale 1ns / 1ps

package tpsd_pkg;

    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int COORD_W    = 17;
    localparam int DELTA_W    = 18;
    localparam int SENS_W     = 16;
    localparam int SPEED_W    = 17;
    localparam int PATH_W     = 20;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // serial multiplier: 17 x 17 -> 34, one multiplier bit per cycle
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // serial root: 36-bit radicand, one root bit per cycle
    localparam int RAD_W  = 36;
    localparam int ROOT_W = RAD_W / 2;

    localparam logic [COORD_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [COORD_W-1:0] SD_MAX  = 17'd131071;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_POSITIONS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MOVEMENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS    = 3'd5;

endpackage

### rtl/core/tracked_point_swipe_detector.sv
`timescale 1ns / 1ps

// Tracked-point swipe detector.
// Input channel (i_in_valid / o_in_ready): one item is either a time tick
// (i_op = 0) or one tracked point of a frame (i_op = 1), points in index order.
// Output channel (o_out_valid / i_out_ready): at most one result item per point,
// carrying the accumulated position and/or a detected swipe vector.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, write only, while idle.
// Work per item, accept to ready again: a tick or an ignored point is taken
// at once; a point without frame match goes through read, start and finish;
// a matched point adds the scaled delta and, with movement and an open gate, squares and root.
// The arithmetic runs in the bit-serial multipliers (scaled delta and the
// squares) and the serial root (18 root bits). One item is worked on at a
// time. A finished result sits in the output register; the next item is
// accepted meanwhile, and only the end of its work waits while the receiver
// stalls.
// Reset (synchronous, active low) loads the register defaults, clears the
// position accumulators (valid bits), frame state, tick count and path.
// Memories: previous and accumulated coordinates, MAX_POINTS entries each.

module tracked_point_swipe_detector #(
    parameter int MAX_POINTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [tpsd_pkg::IDX_W-1:0]      i_point_index,
    input  logic [tpsd_pkg::CNT_W-1:0]      i_point_count,
    input  logic [tpsd_pkg::COORD_W-1:0]    i_point_x,
    input  logic [tpsd_pkg::COORD_W-1:0]    i_point_y,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tpsd_pkg::IDX_W-1:0]      o_out_index,
    output logic                            o_pos_valid,
    output logic [tpsd_pkg::COORD_W-1:0]    o_pos_x,
    output logic [tpsd_pkg::COORD_W-1:0]    o_pos_y,
    output logic                            o_move_valid,
    output logic signed [tpsd_pkg::DELTA_W-1:0] o_move_dx,
    output logic signed [tpsd_pkg::DELTA_W-1:0] o_move_dy,
    output logic [tpsd_pkg::PATH_W-1:0]     o_move_length,
    input  logic                            i_cfg_we,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpsd_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_SCALE,
        S_SQUARE,
        S_ROOT,
        S_FINISH
    } t_state;

    t_state r_state;

    // configuration
    logic               r_en_pos;
    logic               r_en_mov;
    logic [SENS_W-1:0]  r_sens;
    logic [SPEED_W-1:0] r_min_speed;
    logic [PATH_W-1:0]  r_min_size;
    logic [TICK_W-1:0]  r_timeout;

    // frame / movement state
    logic [CNT_W-1:0]   r_prev_count;
    logic               r_frame_match;
    logic               r_gate_open;
    logic [TICK_W-1:0]  r_elapsed;
    logic [PATH_W-1:0]  r_path;
    logic [COORD_W-1:0] r_start_x;
    logic [COORD_W-1:0] r_start_y;
    logic [MAX_POINTS-1:0] r_acc_vld;

    // current item
    logic [IDX_W-1:0]   r_idx;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               r_dx_neg;
    logic               r_dy_neg;

    // memories and their registered read data
    logic [COORD_W-1:0] r_prev_x_mem [MAX_POINTS];
    logic [COORD_W-1:0] r_prev_y_mem [MAX_POINTS];
    logic [COORD_W-1:0] r_acc_x_mem  [MAX_POINTS];
    logic [COORD_W-1:0] r_acc_y_mem  [MAX_POINTS];
    logic [COORD_W-1:0] r_prx_q;
    logic [COORD_W-1:0] r_pry_q;
    logic [COORD_W-1:0] r_accx_q;
    logic [COORD_W-1:0] r_accy_q;

    // arithmetic unit control
    logic               r_mul_start;
    logic               r_sqrt_start;
    logic [MUL_W-1:0]   r_mul_ax;
    logic [MUL_W-1:0]   r_mul_bx;
    logic [MUL_W-1:0]   r_mul_ay;
    logic [MUL_W-1:0]   r_mul_by;

    // result being built
    logic               r_pv;
    logic [COORD_W-1:0] r_res_x;
    logic [COORD_W-1:0] r_res_y;
    logic               r_mv;
    logic [DELTA_W-1:0] r_res_dx;
    logic [DELTA_W-1:0] r_res_dy;
    logic [PATH_W-1:0]  r_res_len;

    // output register
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_o_index;
    logic               r_o_pv;
    logic [COORD_W-1:0] r_o_px;
    logic [COORD_W-1:0] r_o_py;
    logic               r_o_mv;
    logic [DELTA_W-1:0] r_o_dx;
    logic [DELTA_W-1:0] r_o_dy;
    logic [PATH_W-1:0]  r_o_len;

    logic [AW-1:0]      w_slot;
    logic               w_in_range;
    logic [DELTA_W-1:0] w_dx;
    logic [DELTA_W-1:0] w_dy;
    logic [DELTA_W-1:0] w_dx_abs;
    logic [DELTA_W-1:0] w_dy_abs;
    logic               w_mulx_done;
    logic               w_muly_done;
    logic               w_mul_done;
    logic [PROD_W-1:0]  w_prodx;
    logic [PROD_W-1:0]  w_prody;
    logic [PROD_W:0]    w_rndx;
    logic [PROD_W:0]    w_rndy;
    logic [COORD_W-1:0] w_sx_mag;
    logic [COORD_W-1:0] w_sy_mag;
    logic [DELTA_W-1:0] w_sx;
    logic [DELTA_W-1:0] w_sy;
    logic [COORD_W-1:0] w_accx_old;
    logic [COORD_W-1:0] w_accy_old;
    logic [DELTA_W:0]   w_accx_sum;
    logic [DELTA_W:0]   w_accy_sum;
    logic [COORD_W-1:0] w_accx_new;
    logic [COORD_W-1:0] w_accy_new;
    logic [RAD_W-1:0]   w_radicand;
    logic               w_sqrt_done;
    logic [ROOT_W-1:0]  w_step;
    logic               w_fast;
    logic               w_path_zero;
    logic [COORD_W-1:0] w_start_x;
    logic [COORD_W-1:0] w_start_y;
    logic [PATH_W:0]    w_psum;
    logic [PATH_W-1:0]  w_psat;
    logic               w_trig;
    logic               w_has_res;
    logic               w_fin_go;
    logic               w_out_load;
    logic               w_prev_we;
    logic               w_acc_we;

    function automatic logic [COORD_W-1:0] clamp_unit(input logic [DELTA_W:0] s);
        logic [COORD_W-1:0] res;
        if (s[DELTA_W]) begin
            res = '0;
        end else if (s[DELTA_W-1:0] > {1'b0, ONE_Q16}) begin
            res = ONE_Q16;
        end else begin
            res = s[COORD_W-1:0];
        end
        return res;
    endfunction

    assign w_slot     = AW'(r_idx);
    assign w_in_range = (i_point_index < i_point_count[IDX_W:0] || i_point_count[CNT_W-1])
                        && (32'(i_point_index) < MAX_POINTS);

    // raw deltas and magnitudes
    assign w_dx     = {1'b0, r_x} - {1'b0, r_prx_q};
    assign w_dy     = {1'b0, r_y} - {1'b0, r_pry_q};
    assign w_dx_abs = w_dx[DELTA_W-1] ? (DELTA_W'(0) - w_dx) : w_dx;
    assign w_dy_abs = w_dy[DELTA_W-1] ? (DELTA_W'(0) - w_dy) : w_dy;

    tpsd_serial_mul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_ax),
        .i_b     (r_mul_bx),
        .o_done  (w_mulx_done),
        .o_prod  (w_prodx)
    );

    tpsd_serial_mul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_ay),
        .i_b     (r_mul_by),
        .o_done  (w_muly_done),
        .o_prod  (w_prody)
    );

    assign w_mul_done = w_mulx_done & w_muly_done;

    // scaled delta: round half away from zero, saturate magnitude
    assign w_rndx   = {1'b0, w_prodx} + (PROD_W+1)'(128);
    assign w_rndy   = {1'b0, w_prody} + (PROD_W+1)'(128);
    assign w_sx_mag = (|w_rndx[PROD_W:COORD_W+8]) ? SD_MAX : w_rndx[COORD_W+7:8];
    assign w_sy_mag = (|w_rndy[PROD_W:COORD_W+8]) ? SD_MAX : w_rndy[COORD_W+7:8];
    assign w_sx     = r_dx_neg ? (DELTA_W'(0) - {1'b0, w_sx_mag}) : {1'b0, w_sx_mag};
    assign w_sy     = r_dy_neg ? (DELTA_W'(0) - {1'b0, w_sy_mag}) : {1'b0, w_sy_mag};

    assign w_accx_old = r_acc_vld[w_slot] ? r_accx_q : '0;
    assign w_accy_old = r_acc_vld[w_slot] ? r_accy_q : '0;
    assign w_accx_sum = {2'b00, w_accx_old} + {w_sx[DELTA_W-1], w_sx};
    assign w_accy_sum = {2'b00, w_accy_old} + {w_sy[DELTA_W-1], w_sy};
    assign w_accx_new = clamp_unit(w_accx_sum);
    assign w_accy_new = clamp_unit(w_accy_sum);

    // squares are held in the multipliers while the root runs
    assign w_radicand = RAD_W'(w_prodx) + RAD_W'(w_prody);

    tpsd_serial_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (w_radicand),
        .o_done     (w_sqrt_done),
        .o_root     (w_step)
    );

    assign w_fast      = (w_step > {1'b0, r_min_speed});
    assign w_path_zero = (r_path == '0);
    assign w_start_x   = w_path_zero ? r_x : r_start_x;
    assign w_start_y   = w_path_zero ? r_y : r_start_y;
    assign w_psum      = {1'b0, r_path} + (PATH_W+1)'(w_step);
    assign w_psat      = w_psum[PATH_W] ? '1 : w_psum[PATH_W-1:0];
    assign w_trig      = (w_psat >= r_min_size);

    assign w_has_res  = r_pv | r_mv;
    assign w_fin_go   = !w_has_res || !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_FINISH) && w_fin_go && w_has_res;
    assign w_prev_we  = (r_state == S_FINISH) && w_fin_go;
    assign w_acc_we   = (r_state == S_SCALE) && w_mul_done && r_en_pos;

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            r_prev_x_mem[w_slot] <= r_x;
            r_prev_y_mem[w_slot] <= r_y;
        end
        if (w_acc_we) begin
            r_acc_x_mem[w_slot] <= w_accx_new;
            r_acc_y_mem[w_slot] <= w_accy_new;
        end
        r_prx_q  <= r_prev_x_mem[w_slot];
        r_pry_q  <= r_prev_y_mem[w_slot];
        r_accx_q <= r_acc_x_mem[w_slot];
        r_accy_q <= r_acc_y_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_en_pos      <= 1'b1;
            r_en_mov      <= 1'b1;
            r_sens        <= SENS_W'(256);
            r_min_speed   <= SPEED_W'(655);
            r_min_size    <= PATH_W'(6554);
            r_timeout     <= TICK_W'(500);
            r_prev_count  <= '0;
            r_frame_match <= 1'b0;
            r_gate_open   <= 1'b0;
            r_elapsed     <= '0;
            r_path        <= '0;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_acc_vld     <= '0;
            r_mul_start   <= 1'b0;
            r_sqrt_start  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mul_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE_POSITIONS: r_en_pos    <= i_cfg_data[0];
                    CFG_ENABLE_MOVEMENT:  r_en_mov    <= i_cfg_data[0];
                    CFG_SENSITIVITY:      r_sens      <= i_cfg_data[SENS_W-1:0];
                    CFG_MIN_SPEED:        r_min_speed <= i_cfg_data[SPEED_W-1:0];
                    CFG_MIN_SIZE:         r_min_size  <= i_cfg_data[PATH_W-1:0];
                    CFG_TIMEOUT_TICKS:    r_timeout   <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx <= i_point_index;
                        r_x   <= i_point_x;
                        r_y   <= i_point_y;
                        if (!i_op) begin
                            if (r_elapsed != '1) begin
                                r_elapsed <= r_elapsed + 1'b1;
                            end
                        end else begin
                            // index 0 opens a frame
                            if (i_point_index == '0) begin
                                r_frame_match <= (i_point_count == r_prev_count);
                                r_prev_count  <= i_point_count;
                                r_gate_open   <= (r_elapsed >= r_timeout);
                            end
                            if (w_in_range) begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_pv      <= 1'b0;
                    r_res_x   <= '0;
                    r_res_y   <= '0;
                    r_mv      <= 1'b0;
                    r_res_dx  <= '0;
                    r_res_dy  <= '0;
                    r_res_len <= '0;
                    r_dx_neg  <= w_dx[DELTA_W-1];
                    r_dy_neg  <= w_dy[DELTA_W-1];
                    r_mul_ax  <= w_dx_abs[MUL_W-1:0];
                    r_mul_ay  <= w_dy_abs[MUL_W-1:0];
                    r_mul_bx  <= MUL_W'(r_sens);
                    r_mul_by  <= MUL_W'(r_sens);
                    if (r_frame_match) begin
                        r_mul_start <= 1'b1;
                        r_state     <= S_SCALE;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_SCALE: begin
                    if (w_mul_done) begin
                        if (r_en_pos) begin
                            r_pv              <= 1'b1;
                            r_res_x           <= w_accx_new;
                            r_res_y           <= w_accy_new;
                            r_acc_vld[w_slot] <= 1'b1;
                        end
                        if (r_en_mov && r_gate_open) begin
                            r_mul_ax    <= w_sx_mag;
                            r_mul_bx    <= w_sx_mag;
                            r_mul_ay    <= w_sy_mag;
                            r_mul_by    <= w_sy_mag;
                            r_mul_start <= 1'b1;
                            r_state     <= S_SQUARE;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_SQUARE: begin
                    if (w_mul_done) begin
                        r_sqrt_start <= 1'b1;
                        r_state      <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_sqrt_done) begin
                        if (w_fast) begin
                            if (w_path_zero) begin
                                r_start_x <= r_x;
                                r_start_y <= r_y;
                            end
                            if (w_trig) begin
                                r_mv      <= 1'b1;
                                r_res_dx  <= {1'b0, r_x} - {1'b0, w_start_x};
                                r_res_dy  <= {1'b0, r_y} - {1'b0, w_start_y};
                                r_res_len <= w_psat;
                                r_path    <= '0;
                                r_elapsed <= '0;
                            end else begin
                                r_path <= w_psat;
                            end
                        end else begin
                            r_path <= '0;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_fin_go) begin
                        if (w_has_res) begin
                            r_out_valid <= 1'b1;
                            r_o_index   <= r_idx;
                            r_o_pv      <= r_pv;
                            r_o_px      <= r_res_x;
                            r_o_py      <= r_res_y;
                            r_o_mv      <= r_mv;
                            r_o_dx      <= r_res_dx;
                            r_o_dy      <= r_res_dy;
                            r_o_len     <= r_res_len;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_index   = r_o_index;
    assign o_pos_valid   = r_o_pv;
    assign o_pos_x       = r_o_px;
    assign o_pos_y       = r_o_py;
    assign o_move_valid  = r_o_mv;
    assign o_move_dx     = r_o_dx;
    assign o_move_dy     = r_o_dy;
    assign o_move_length = r_o_len;

endmodule

### rtl/core/tpsd_serial_mul.sv
`timescale 1ns / 1ps

module tpsd_serial_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tpsd_pkg::MUL_W-1:0]  i_a,
    input  logic [tpsd_pkg::MUL_W-1:0]  i_b,
    output logic                        o_done,
    output logic [tpsd_pkg::PROD_W-1:0] o_prod
);
    import tpsd_pkg::*;

    localparam int CW = $clog2(MUL_W);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [MUL_W-1:0]    r_a;
    logic [MUL_W-1:0]    r_b;
    logic [PROD_W-1:0]   r_p;
    logic [MUL_W:0]      w_sum;

    // shift-add, LSB of the multiplier first; product shifts right into place
    assign w_sum = {1'b0, r_p[PROD_W-1:MUL_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
            end else if (r_busy) begin
                r_p <= {w_sum, r_p[MUL_W-1:1]};
                r_b <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

### rtl/core/tpsd_serial_sqrt.sv
`timescale 1ns / 1ps

module tpsd_serial_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tpsd_pkg::RAD_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [tpsd_pkg::ROOT_W-1:0] o_root
);
    import tpsd_pkg::*;

    localparam int CW    = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [RAD_W-1:0]    r_v;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [REM_W+1:0]    w_sh;
    logic [REM_W+1:0]    w_trial;
    logic                w_take;

    // restoring digit recurrence, two radicand bits per step
    assign w_sh    = {r_rem, r_v[RAD_W-1:RAD_W-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_take  = (w_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v <= r_v << 2;
                if (w_take) begin
                    r_rem  <= REM_W'(w_sh - w_trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/core/tpsd_checker.sv
`timescale 1ns / 1ps

module tpsd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [tpsd_pkg::IDX_W-1:0]      o_out_index,
    input logic                            o_pos_valid,
    input logic [tpsd_pkg::COORD_W-1:0]    o_pos_x,
    input logic [tpsd_pkg::COORD_W-1:0]    o_pos_y,
    input logic                            o_move_valid,
    input logic signed [tpsd_pkg::DELTA_W-1:0] o_move_dx,
    input logic signed [tpsd_pkg::DELTA_W-1:0] o_move_dy,
    input logic [tpsd_pkg::PATH_W-1:0]     o_move_length
);
    import tpsd_pkg::*;

    // a stalled item holds its index, position and length
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_index)
            && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_move_length))
        else $error("output item changed while stalled");

    // an item carries a position, a swipe or both
    a_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pos_valid || o_move_valid)
        else $error("empty output item");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pos_valid ? (o_pos_x <= ONE_Q16 && o_pos_y <= ONE_Q16)
                                     : (o_pos_x == '0 && o_pos_y == '0)))
        else $error("position field out of range or not zeroed");

    a_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_move_valid |->
            o_move_dx == '0 && o_move_dy == '0 && o_move_length == '0)
        else $error("swipe fields set without a swipe");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind tracked_point_swipe_detector tpsd_checker u_tpsd_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tpsd_pkg::*;

    typedef enum logic {OP_TICK = 1'b0, OP_POINT = 1'b1} t_op;

    localparam int POINTS        = 16;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 75;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRETICK_MAX   = 64;
    localparam longint PATH_TOP  = 1048575;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point_item;

    typedef struct {
        logic [IDX_W-1:0]          index;
        logic                      pos_valid;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic                      move_valid;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [PATH_W-1:0]         length;
    } t_swipe_result;

    typedef struct {
        bit          pos_on;
        bit          move_on;
        int unsigned gain;
        int unsigned speed_floor;
        int unsigned size_goal;
        int unsigned hold;
        bit          calm;
    } t_setting;

    // Shadow of the detector: registers, frame state, and the results still owed.
    class swipe_scoreboard;
        bit                 pos_on, move_on;
        logic [SENS_W-1:0]  gain;
        logic [SPEED_W-1:0] speed_floor;
        logic [PATH_W-1:0]  size_goal;
        logic [TICK_W-1:0]  hold;

        logic [COORD_W-1:0] last_x[POINTS], last_y[POINTS];
        logic [COORD_W-1:0] sum_x[POINTS], sum_y[POINTS];
        bit                 written[POINTS];
        logic [CNT_W-1:0]   last_count;
        bit                 same_count, gate;
        logic [TICK_W-1:0]  ticks;
        logic [PATH_W-1:0]  path;
        logic [COORD_W-1:0] org_x, org_y;
        t_swipe_result      due[$];
        int                 errors;

        function new();
            pos_on      = 1'b1;
            move_on     = 1'b1;
            gain        = 16'd256;
            speed_floor = 17'd655;
            size_goal   = 20'd6554;
            hold        = 16'd500;
            for (int i = 0; i < POINTS; i++) begin
                last_x[i]  = '0;
                last_y[i]  = '0;
                sum_x[i]   = '0;
                sum_y[i]   = '0;
                written[i] = 1'b0;
            end
            last_count = '0;
            same_count = 1'b0;
            gate       = 1'b0;
            ticks      = '0;
            path       = '0;
            org_x      = '0;
            org_y      = '0;
            errors     = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_DATA_W-1:0] value);
            case (which)
                CFG_ENABLE_POSITIONS: pos_on      = value[0];
                CFG_ENABLE_MOVEMENT:  move_on     = value[0];
                CFG_SENSITIVITY:      gain        = value[SENS_W-1:0];
                CFG_MIN_SPEED:        speed_floor = value[SPEED_W-1:0];
                CFG_MIN_SIZE:         size_goal   = value[PATH_W-1:0];
                CFG_TIMEOUT_TICKS:    hold        = value[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // gain is Q8.8; magnitude rounds half away from zero, then saturates
        function longint scaled(logic [COORD_W-1:0] now, logic [COORD_W-1:0] was);
            longint d, m, s;
            d = longint'(now) - longint'(was);
            m = (d < 0) ? -d : d;
            s = (m * longint'(gain) + 128) >>> 8;
            if (s > longint'(SD_MAX)) s = longint'(SD_MAX);
            return (d < 0) ? -s : s;
        endfunction

        function longint root_floor(longint v);
            longint r, trial;
            r = 0;
            for (int k = 18; k >= 0; k--) begin
                trial = r | (longint'(1) << k);
                if (trial * trial <= v) r = trial;
            end
            return r;
        endfunction

        function logic [COORD_W-1:0] clamp_unit(longint v);
            if (v < 0) return '0;
            if (v > longint'(ONE_Q16)) return ONE_Q16;
            return COORD_W'(v);
        endfunction

        // true when this point would look back at a slot nothing has stored yet
        function bit reads_unwritten(t_point_item it);
            bit hit;
            if (it.op == OP_TICK || it.idx >= it.cnt) return 1'b0;
            hit = (it.idx == 0) ? (it.cnt == last_count) : same_count;
            return hit && !written[it.idx];
        endfunction

        function void note_input(t_point_item it);
            t_swipe_result want;
            longint        sx, sy, step, grown;
            if (it.op == OP_TICK) begin
                if (ticks != '1) ticks++;
                return;
            end
            if (it.idx == 0) begin
                same_count = (it.cnt == last_count);
                last_count = it.cnt;
                gate       = (ticks >= hold);
            end
            if (it.idx >= it.cnt) return;

            want       = '{default: '0};
            want.index = it.idx;
            if (same_count) begin
                sx = scaled(it.x, last_x[it.idx]);
                sy = scaled(it.y, last_y[it.idx]);
                if (pos_on) begin
                    sum_x[it.idx]  = clamp_unit(longint'(sum_x[it.idx]) + sx);
                    sum_y[it.idx]  = clamp_unit(longint'(sum_y[it.idx]) + sy);
                    want.pos_valid = 1'b1;
                    want.pos_x     = sum_x[it.idx];
                    want.pos_y     = sum_y[it.idx];
                end
                if (move_on && gate) begin
                    step = root_floor(sx * sx + sy * sy);
                    if (step > longint'(speed_floor)) begin
                        if (path == 0) begin
                            org_x = it.x;
                            org_y = it.y;
                        end
                        grown = longint'(path) + step;
                        path  = PATH_W'((grown > PATH_TOP) ? PATH_TOP : grown);
                        if (path >= size_goal) begin
                            want.move_valid = 1'b1;
                            want.dx         = DELTA_W'(longint'(it.x) - longint'(org_x));
                            want.dy         = DELTA_W'(longint'(it.y) - longint'(org_y));
                            want.length     = path;
                            path            = '0;
                            ticks           = '0;
                        end
                    end else begin
                        path = '0;
                    end
                end
            end
            last_x[it.idx]  = it.x;
            last_y[it.idx]  = it.y;
            written[it.idx] = 1'b1;
            if (want.pos_valid || want.move_valid) due.insert(due.size(), want);
        endfunction

        function void match_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_swipe_result got);
            t_swipe_result want;
            if (due.size() == 0) begin
                $display("%0t: result for point %0d, expected none, actual pos_valid=%0b move_valid=%0b",
                         $time, got.index, got.pos_valid, got.move_valid);
                errors++;
                return;
            end
            want = due.pop_front();
            match_field("out_index", want.index, got.index);
            match_field("pos_valid", want.pos_valid, got.pos_valid);
            match_field("pos_x", want.pos_x, got.pos_x);
            match_field("pos_y", want.pos_y, got.pos_y);
            match_field("move_valid", want.move_valid, got.move_valid);
            match_field("move_dx", want.dx, got.dx);
            match_field("move_dy", want.dy, got.dy);
            match_field("move_length", want.length, got.length);
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_ready;
    logic                      i_op          = 1'b0;
    logic [IDX_W-1:0]          i_point_index = '0;
    logic [CNT_W-1:0]          i_point_count = '0;
    logic [COORD_W-1:0]        i_point_x     = '0;
    logic [COORD_W-1:0]        i_point_y     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready   = 1'b0;
    logic [IDX_W-1:0]          o_out_index;
    logic                      o_pos_valid;
    logic [COORD_W-1:0]        o_pos_x;
    logic [COORD_W-1:0]        o_pos_y;
    logic                      o_move_valid;
    logic signed [DELTA_W-1:0] o_move_dx;
    logic signed [DELTA_W-1:0] o_move_dy;
    logic [PATH_W-1:0]         o_move_length;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data    = '0;

    swipe_scoreboard book;
    t_swipe_result   seen_res;
    bit              calm   = 1'b0;
    int              fed    = 0;
    int unsigned     cycles = 0;

    // a timeout of 65535 keeps the gate shut for the whole phase
    t_setting plan[PHASES] = '{
        '{1'b1, 1'b1,   256,    655,    6554,     0, 1'b0},
        '{1'b1, 1'b1, 65535,      0,       0,     0, 1'b1},
        '{1'b0, 1'b1,   512, 131071, 1048575,     0, 1'b0},
        '{1'b1, 1'b0,     0,    655,    6554,     3, 1'b0},
        '{1'b1, 1'b1,  2048,    655,    6554, 65535, 1'b0},
        '{1'b1, 1'b1,   300,    200,    3000,     5, 1'b0},
        '{1'b0, 1'b0,   256,    655,    6554,     0, 1'b0},
        '{1'b1, 1'b1,  1024,   1000, 1048575,     0, 1'b0},
        '{1'b1, 1'b1,   256,    655,    6554,    40, 1'b0}
    };

    tracked_point_swipe_detector #(.MAX_POINTS(POINTS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_point_index (i_point_index),
        .i_point_count (i_point_count),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_index   (o_out_index),
        .o_pos_valid   (o_pos_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_move_valid  (o_move_valid),
        .o_move_dx     (o_move_dx),
        .o_move_dy     (o_move_dy),
        .o_move_length (o_move_length),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_res.index      = o_out_index;
            seen_res.pos_valid  = o_pos_valid;
            seen_res.pos_x      = o_pos_x;
            seen_res.pos_y      = o_pos_y;
            seen_res.move_valid = o_move_valid;
            seen_res.dx         = o_move_dx;
            seen_res.dy         = o_move_dy;
            seen_res.length     = o_move_length;
            book.check_result(seen_res);
        end
    end

    function automatic t_point_item point_at(int idx, int cnt, int x, int y);
        t_point_item it;
        it.op  = OP_POINT;
        it.idx = IDX_W'(idx);
        it.cnt = CNT_W'(cnt);
        it.x   = COORD_W'(x);
        it.y   = COORD_W'(y);
        return it;
    endfunction

    // tick payload is don't-care, so it carries random bits
    function automatic t_point_item tick_item();
        t_point_item it;
        it.op  = OP_TICK;
        it.idx = IDX_W'($urandom);
        it.cnt = CNT_W'($urandom);
        it.x   = COORD_W'($urandom);
        it.y   = COORD_W'($urandom);
        return it;
    endfunction

    function automatic int coord_pick();
        case ($urandom_range(7))
            0: return 0;
            1: return 65536;
            2: return 131071;
            3: return 65535;
            default: return $urandom_range(0, 131071);
        endcase
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 1;
        if (r < 75) return 2;
        if (r < 90) return $urandom_range(3, 4);
        return $urandom_range(5, POINTS);
    endfunction

    // one frame of motion, bouncing off the unit square
    function automatic void glide(inout int pos, inout int vel, input int vmax);
        int jig;
        jig = vmax / 4;
        pos += vel + int'($urandom_range(0, 2 * jig)) - jig;
        if (pos < 0) begin
            pos = -pos;
            vel = -vel;
        end
        if (pos > 65536) begin
            pos = 131072 - pos;
            vel = -vel;
        end
        if (pos < 0) pos = 0;
        if (pos > 65536) pos = 65536;
    endfunction

    task automatic send_item(input t_point_item it);
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_point_index <= it.idx;
        i_point_count <= it.cnt;
        i_point_x     <= it.x;
        i_point_y     <= it.y;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic offer(input t_point_item it);
        if (book.reads_unwritten(it)) return;
        send_item(it);
        if (it.op == OP_TICK || it.idx < it.cnt) fed++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) offer(tick_item());
    endtask

    task automatic poke_reg(input logic [CFG_IDX_W-1:0] which, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(negedge i_clk);
        book.load_reg(which, CFG_DATA_W'(value));
    endtask

    // registers only change with nothing in flight
    task automatic apply_setting(input t_setting s);
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        calm <= s.calm;
        poke_reg(CFG_ENABLE_POSITIONS, s.pos_on);
        poke_reg(CFG_ENABLE_MOVEMENT, s.move_on);
        poke_reg(CFG_SENSITIVITY, s.gain);
        poke_reg(CFG_MIN_SPEED, s.speed_floor);
        poke_reg(CFG_MIN_SIZE, s.size_goal);
        poke_reg(CFG_TIMEOUT_TICKS, s.hold);
        poke_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        // one tick past a short timeout, so the gate is open at the next frame
        if (s.hold != 0 && s.hold <= PRETICK_MAX) send_ticks(s.hold + 1);
    endtask

    task automatic run_directed();
        offer(point_at(0, 1, 0, 0));            // first frame never matches
        offer(point_at(0, 1, 65536, 65536));    // full-scale jump, clamps at 1.0
        offer(point_at(0, 1, 0, 0));            // clamps at 0
        offer(point_at(0, 1, 100, 0));          // slow step clears the path
        offer(point_at(0, 1, 1000, 0));
        offer(point_at(0, 1, 5000, 0));
        offer(point_at(0, 1, 9000, 3000));      // path reaches min size
        offer(tick_item());
        offer(point_at(0, 2, 131071, 131071));  // coordinates above 1.0
        offer(point_at(1, 2, 0, 65536));
        offer(point_at(2, 2, 500, 500));        // index beyond count
        offer(point_at(0, 2, 0, 0));            // largest delta, scaled exactly to SD_MAX
        offer(point_at(1, 2, 131071, 0));
        offer(point_at(0, 16, 1, 2));
        offer(point_at(15, 16, 65535, 7));
        offer(point_at(0, 16, 40000, 20000));
        offer(point_at(15, 16, 0, 131071));
        offer(point_at(0, 0, 777, 888));        // zero count: frame start only
        offer(point_at(7, 31, 131071, 65536));
        offer(tick_item());
    endtask

    task automatic run_motion();
        int n_pts, frames, vmax, skip;
        int px[POINTS], py[POINTS], vx[POINTS], vy[POINTS];
        n_pts  = pick_count();
        frames = $urandom_range(3, 12);
        case ($urandom_range(3))
            0: vmax = 60;
            1: vmax = 900;
            2: vmax = 4000;
            default: vmax = 20000;
        endcase
        for (int p = 0; p < n_pts; p++) begin
            px[p] = $urandom_range(0, 65536);
            py[p] = $urandom_range(0, 65536);
            vx[p] = int'($urandom_range(0, 2 * vmax)) - vmax;
            vy[p] = int'($urandom_range(0, 2 * vmax)) - vmax;
        end
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(99) < 30) send_ticks($urandom_range(1, 8));
            // now and then a frame loses a point
            skip = ($urandom_range(99) < 8) ? int'($urandom_range(0, n_pts - 1)) : -1;
            for (int p = 0; p < n_pts; p++) begin
                if (f > 0) begin
                    glide(px[p], vx[p], vmax);
                    glide(py[p], vy[p], vmax);
                end
                if (p != skip) offer(point_at(p, n_pts, px[p], py[p]));
            end
        end
    endtask

    task automatic run_noise();
        t_point_item it;
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(99) < 20) begin
                it = tick_item();
            end else begin
                it = point_at($urandom_range(0, 15), $urandom_range(0, 31),
                              coord_pick(), coord_pick());
            end
            offer(it);
        end
    endtask

    initial begin
        book = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            apply_setting(plan[ph]);
            if (ph == 0) run_directed();
            fed = 0;
            while (fed < PHASE_ITEMS) begin
                if ($urandom_range(99) < 75) begin
                    run_motion();
                end else begin
                    run_noise();
                end
            end
        end
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (book.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
